[hw/rtl/eifc_pkg.sv]
// eifc_pkg: shared constants and types for the eased interpolation block
// no dependencies; used by eased_interpolation_four_curve
package eifc_pkg;

  localparam int unsigned TimeBits = 16;
  localparam logic [15:0] TimeMask = 16'((32'd1 << TimeBits) - 32'd1);

  localparam int unsigned DvdBits  = 64;
  localparam int unsigned DivSteps = DvdBits;

  localparam logic [2:0] ModeLinear  = 3'd0;
  localparam logic [2:0] ModeEaseIn  = 3'd1;
  localparam logic [2:0] ModeEaseOut = 3'd2;
  localparam logic [2:0] ModeSmooth  = 3'd3;

  // q12 one and rounding half
  localparam logic [13:0] QOne   = 14'h1000;
  localparam logic [11:0] QRound = 12'h800;

  typedef struct packed {
    logic [31:0] s;
    logic [31:0] e;
    logic [31:0] diff;
    logic [31:0] wt;
    logic [2:0]  mode;
    logic        special;
    logic        neg;
    logic        half_lo;
  } ctx_t;

endpackage

[hw/rtl/eased_interpolation_four_curve.sv]
// eased_interpolation_four_curve: pipelined tween evaluator
// depends on eifc_pkg (constants, ctx_t)
//
// a result passes the stage a, stage b, divider, p0, p1, p2 and output registers in order
// throughput: one beat per clock; busy_o is tied low, the pipeline never stalls
// latency is set by the 64-stage restoring divider, one quotient bit per stage
// reset clears only the valid bits; payload registers are left as they are
module eased_interpolation_four_curve (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [31:0] start_value_i,
  input  logic signed [31:0] end_value_i,
  input  logic [15:0]        elapsed_time_i,
  input  logic [15:0]        total_time_i,
  input  logic [2:0]         mode_i,
  output logic               done_o,
  output logic signed [31:0] result_value_o
);

  localparam int unsigned Latency = eifc_pkg::DivSteps + 7;
  localparam int unsigned DS      = eifc_pkg::DivSteps;

  logic accept;

  // stage a: captured input beat
  logic        a_vld_q;
  logic [31:0] a_s_q, a_e_q;
  logic [15:0] a_el_q, a_tot_q;
  logic [2:0]  a_mode_q;

  // stage b: difference, magnitude, weight base
  eifc_pkg::ctx_t b_ctx_d, b_ctx_q;
  logic        b_vld_q;
  logic [31:0] b_mag_d, b_mag_q;
  logic [15:0] b_w_d, b_w_q;
  logic [15:0] b_el_q, b_tot_q;

  // stage c feeds divider stage 0
  logic [47:0] c_lin;
  logic [31:0] c_tsq;
  logic [31:0] c_wt;
  logic [63:0] c_dvd;
  logic [31:0] c_dvs;
  eifc_pkg::ctx_t c_ctx;

  // divider pipeline
  logic           dv_vld_q [DS+1];
  logic [63:0]    dq_q     [DS+1];
  logic [31:0]    rem_q    [DS+1];
  logic [31:0]    dvs_q    [DS+1];
  eifc_pkg::ctx_t dctx_q   [DS+1];
  logic [32:0]    trial    [DS];
  logic [32:0]    diffr    [DS];
  logic           ge       [DS];
  logic [63:0]    dq_n     [DS];
  logic [31:0]    rem_n    [DS];

  // post stages
  logic           p0_vld_q, p1_vld_q, p2_vld_q;
  eifc_pkg::ctx_t p0_ctx_q, p1_ctx_q, p2_ctx_q;
  logic [63:0]    p0_q_d, p0_q_q;
  logic [63:0]    p1_m1;
  logic [31:0]    p1_m2;
  logic signed [13:0] p1_off;
  logic signed [27:0] p1_offsq;
  logic [31:0]    p1_m1h_q, p1_m2_q, p1_q32_q;
  logic [24:0]    p1_offsq_q;
  logic [25:0]    p2_sqr;
  logic [12:0]    p2_sq, p2_x;
  logic [31:0]    p2_hi;
  logic signed [31:0] p2_h;
  logic signed [45:0] p2_prod;
  logic [31:0]    p2_hi_q, p2_q32_q, p2_h_q;
  logic signed [45:0] p2_prod_q;
  logic [45:0]    o_rnd;
  logic [31:0]    o_t;
  logic [31:0]    res_d, res_q;
  logic           done_q;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // ---------------- stage a: input capture ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else begin
      a_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    a_s_q    <= start_value_i;
    a_e_q    <= end_value_i;
    a_el_q   <= elapsed_time_i & eifc_pkg::TimeMask;
    a_tot_q  <= total_time_i & eifc_pkg::TimeMask;
    a_mode_q <= mode_i;
  end

  // ---------------- stage b: wrapped difference and its magnitude ----------------
  always_comb begin
    b_ctx_d.s       = a_s_q;
    b_ctx_d.e       = a_e_q;
    b_ctx_d.diff    = a_e_q - a_s_q;
    b_ctx_d.wt      = '0;
    b_ctx_d.mode    = a_mode_q;
    // equal endpoints or time used up give the end value
    b_ctx_d.special = (a_s_q == a_e_q) | (a_el_q >= a_tot_q);
    b_ctx_d.neg     = b_ctx_d.diff[31];
    b_ctx_d.half_lo = a_el_q < (a_tot_q >> 1);
    b_mag_d = b_ctx_d.diff[31] ? (32'd0 - b_ctx_d.diff) : b_ctx_d.diff;
    // ease-out weighs the remaining time
    b_w_d   = (a_mode_q == eifc_pkg::ModeEaseOut) ? (a_tot_q - a_el_q) : a_el_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_ctx_q <= b_ctx_d;
    b_mag_q <= b_mag_d;
    b_w_q   <= b_w_d;
    b_el_q  <= a_el_q;
    b_tot_q <= a_tot_q;
  end

  // ---------------- stage c: dividend and divisor per curve ----------------
  always_comb begin
    c_lin = {16'd0, b_mag_q} * {32'd0, b_el_q};
    c_tsq = {16'd0, b_tot_q} * {16'd0, b_tot_q};
    c_wt  = {16'd0, b_w_q} * {16'd0, b_w_q};
    c_ctx = b_ctx_q;
    c_ctx.wt  = c_wt;
    // smoothstep fraction is always positive
    c_ctx.neg = b_ctx_q.neg & (b_ctx_q.mode != eifc_pkg::ModeSmooth);
    unique case (b_ctx_q.mode)
      eifc_pkg::ModeLinear: begin
        c_dvd = {16'd0, c_lin};
        c_dvs = {16'd0, b_tot_q};
      end
      eifc_pkg::ModeEaseIn, eifc_pkg::ModeEaseOut: begin
        c_dvd = {b_mag_q, 32'd0};
        c_dvs = c_tsq;
      end
      eifc_pkg::ModeSmooth: begin
        c_dvd = {36'd0, b_el_q, 12'd0};
        c_dvs = {16'd0, b_tot_q};
      end
      default: begin
        c_dvd = '0;
        c_dvs = {16'd0, b_tot_q};
      end
    endcase
  end

  // ---------------- restoring divider, one bit per stage ----------------
  always_comb begin
    for (int k = 0; k < DS; k++) begin
      trial[k] = {rem_q[k], dq_q[k][63]};
      diffr[k] = trial[k] - {1'b0, dvs_q[k]};
      ge[k]    = trial[k] >= {1'b0, dvs_q[k]};
      rem_n[k] = ge[k] ? diffr[k][31:0] : trial[k][31:0];
      dq_n[k]  = {dq_q[k][62:0], ge[k]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= DS; k++) begin
        dv_vld_q[k] <= 1'b0;
      end
    end else begin
      dv_vld_q[0] <= b_vld_q;
      for (int k = 0; k < DS; k++) begin
        dv_vld_q[k+1] <= dv_vld_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q[0]   <= c_dvd;
    rem_q[0]  <= '0;
    dvs_q[0]  <= c_dvs;
    dctx_q[0] <= c_ctx;
    for (int k = 0; k < DS; k++) begin
      dq_q[k+1]   <= dq_n[k];
      rem_q[k+1]  <= rem_n[k];
      dvs_q[k+1]  <= dvs_q[k];
      dctx_q[k+1] <= dctx_q[k];
    end
  end

  // ---------------- p0: signed quotient ----------------
  assign p0_q_d = dctx_q[DS].neg ? (64'd0 - dq_q[DS]) : dq_q[DS];

  // ---------------- p1: weight products, smoothstep square ----------------
  always_comb begin
    p1_m1    = {32'd0, p0_ctx_q.wt} * {32'd0, p0_q_q[31:0]};
    p1_m2    = 32'(p0_ctx_q.wt * p0_q_q[63:32]);
    p1_off   = $signed(eifc_pkg::QOne - {1'b0, p0_q_q[11:0], 1'b0});
    p1_offsq = 28'(p1_off) * 28'(p1_off);
  end

  // ---------------- p2: high word sum, half-curve multiply ----------------
  always_comb begin
    p2_hi   = p1_m1h_q + p1_m2_q;
    p2_sqr  = {1'b0, p1_offsq_q} + {14'd0, eifc_pkg::QRound};
    p2_sq   = p2_sqr[24:12];
    p2_x    = p1_ctx_q.half_lo ? (eifc_pkg::QOne[12:0] - p2_sq) : p2_sq;
    // half of the difference, truncated toward zero
    p2_h    = $signed(p1_ctx_q.diff + {31'd0, p1_ctx_q.diff[31]}) >>> 1;
    p2_prod = 46'(p2_h) * 46'($signed({1'b0, p2_x}));
  end

  // ---------------- output select ----------------
  always_comb begin
    o_rnd = p2_prod_q + {34'd0, eifc_pkg::QRound};
    o_t   = o_rnd[43:12];
    if (p2_ctx_q.special) begin
      res_d = p2_ctx_q.e;
    end else begin
      unique case (p2_ctx_q.mode)
        eifc_pkg::ModeLinear:  res_d = p2_ctx_q.s + p2_q32_q;
        eifc_pkg::ModeEaseIn:  res_d = p2_ctx_q.s + p2_hi_q;
        eifc_pkg::ModeEaseOut: res_d = p2_ctx_q.e - p2_hi_q;
        eifc_pkg::ModeSmooth: begin
          res_d = p2_ctx_q.half_lo ? (p2_ctx_q.s + o_t) : (p2_ctx_q.s + p2_h_q + o_t);
        end
        default:               res_d = p2_ctx_q.s;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_vld_q <= 1'b0;
      p1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      p0_vld_q <= dv_vld_q[DS];
      p1_vld_q <= p0_vld_q;
      p2_vld_q <= p1_vld_q;
      done_q   <= p2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p0_q_q     <= p0_q_d;
    p0_ctx_q   <= dctx_q[DS];
    p1_m1h_q   <= p1_m1[63:32];
    p1_m2_q    <= p1_m2;
    p1_q32_q   <= p0_q_q[31:0];
    p1_offsq_q <= p1_offsq[24:0];
    p1_ctx_q   <= p0_ctx_q;
    p2_hi_q    <= p2_hi;
    p2_q32_q   <= p1_q32_q;
    p2_h_q     <= p2_h;
    p2_prod_q  <= p2_prod;
    p2_ctx_q   <= p1_ctx_q;
    res_q      <= res_d;
  end

  assign done_o         = done_q;
  assign result_value_o = res_q;

  // a result beat always traces back to an accepted beat at fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, Latency))
    else $error("result beat without matching input beat");

  // divider remainder ends below the divisor whenever the quotient is used
  a_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_vld_q[DS] && !dctx_q[DS].special) |-> (rem_q[DS] < dvs_q[DS]))
    else $error("divider remainder not reduced");

  // smoothstep fraction stays within q12
  a_frac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_vld_q[DS] && !dctx_q[DS].special && dctx_q[DS].mode == eifc_pkg::ModeSmooth)
      |-> (dq_q[DS][63:12] == 52'd0))
    else $error("smoothstep fraction out of range");

endmodule
